[src/swa_pkg.sv]
// Shared types and constants for the sliding window moving average unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package swa_pkg;

  localparam int MAX_WINDOW = 256;
  localparam int PTR_W      = $clog2(MAX_WINDOW);
  localparam int CNT_W      = PTR_W + 1;
  localparam int SAMPLE_W   = 32;
  localparam int SUM_W      = SAMPLE_W + PTR_W;
  localparam int FRAC_W     = 16;
  localparam int AVG_W      = 48;
  localparam int DIVD_W     = SUM_W + FRAC_W;
  localparam int STEP_W     = $clog2(DIVD_W);
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  // running sum after an item and the number of samples it covers
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        count;
  } work_t;

  // queue occupancy seen by the front end
  typedef struct packed {
    logic [QCNT_W-1:0] free;
  } q_stat_t;

endpackage

[src/swa_front.sv]
// Front end: accepts samples, keeps the history ring, fill count and running sum.
// Depends on swa_pkg; pushes one work_t per item into swa_queue.
`timescale 1ns / 1ps

module swa_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             win_len_we_i,
  input  logic [swa_pkg::CNT_W-1:0]        win_len_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [swa_pkg::SAMPLE_W-1:0] sample_i,
  input  swa_pkg::q_stat_t                 q_stat_i,
  output logic                             push_o,
  output swa_pkg::work_t                   push_data_o
);
  import swa_pkg::*;

  logic [CNT_W-1:0]         win_q;
  logic [CNT_W-1:0]         eff_w;
  logic [PTR_W-1:0]         wp_q;
  logic [CNT_W-1:0]         fill_q;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic                     full;
  logic                     accept;
  logic [PTR_W-1:0]         oldest;

  logic                     s1_valid_q;
  logic                     s1_sub_q;
  logic signed [SAMPLE_W-1:0] s1_sample_q;
  logic [CNT_W-1:0]         s1_cnt_q;

  logic [SAMPLE_W-1:0]      ring [MAX_WINDOW];
  logic [SAMPLE_W-1:0]      rd_q;

  always_comb begin
    if (win_q == '0) begin
      eff_w = CNT_W'(1);
    end else if (win_q > CNT_W'(MAX_WINDOW)) begin
      eff_w = CNT_W'(MAX_WINDOW);
    end else begin
      eff_w = win_q;
    end
  end

  assign full   = fill_q >= eff_w;
  // ring index wraps, so a full window of MAX_WINDOW lands on wp itself
  assign oldest = wp_q - eff_w[PTR_W-1:0];

  // room for the item in stage 1 plus this one
  assign in_ready_o = s1_valid_q ? (q_stat_i.free >= QCNT_W'(2))
                                 : (q_stat_i.free >= QCNT_W'(1));
  assign accept = in_valid_i & in_ready_o;

  // read happens before the write, so the overwritten slot still reads old data
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ring[wp_q] <= sample_i;
      rd_q       <= ring[oldest];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sample_q <= sample_i;
      s1_sub_q    <= full;
      s1_cnt_q    <= full ? fill_q : fill_q + CNT_W'(1);
    end
  end

  always_comb begin
    sum_d = sum_q + {{(SUM_W-SAMPLE_W){s1_sample_q[SAMPLE_W-1]}}, s1_sample_q};
    if (s1_sub_q) begin
      sum_d = sum_d - {{(SUM_W-SAMPLE_W){rd_q[SAMPLE_W-1]}}, rd_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q      <= CNT_W'(1);
      wp_q       <= '0;
      fill_q     <= '0;
      sum_q      <= '0;
      s1_valid_q <= 1'b0;
    end else if (win_len_we_i) begin
      win_q      <= win_len_i;
      wp_q       <= '0;
      fill_q     <= '0;
      sum_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      if (accept) begin
        wp_q <= wp_q + PTR_W'(1);
        if (!full) begin
          fill_q <= fill_q + CNT_W'(1);
        end
      end
      if (s1_valid_q) begin
        sum_q <= sum_d;
      end
    end
  end

  assign push_o            = s1_valid_q;
  assign push_data_o.sum   = sum_d;
  assign push_data_o.count = s1_cnt_q;

endmodule

[src/swa_queue.sv]
// Two-entry queue that decouples the accumulator front end from the divider.
// Depends on swa_pkg.
`timescale 1ns / 1ps

module swa_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  swa_pkg::work_t   push_data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output swa_pkg::work_t   data_o,
  output swa_pkg::q_stat_t stat_o
);
  import swa_pkg::*;

  work_t               mem_q [QDEPTH];
  logic [QPTR_W-1:0]   rp_q, wp_q;
  logic [QCNT_W-1:0]   cnt_q;
  logic                do_pop;

  assign valid_o     = cnt_q != '0;
  assign data_o      = mem_q[rp_q];
  assign stat_o.free = QCNT_W'(QDEPTH) - cnt_q;
  assign do_pop      = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q  <= '0;
      wp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= wp_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rp_q <= rp_q + QPTR_W'(1);
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

[src/swa_back.sv]
// Back end: bit-serial restoring divider of |sum| << FRAC_W by the count,
// sign restore and the output register. Depends on swa_pkg.
`timescale 1ns / 1ps

module swa_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_valid_i,
  input  swa_pkg::work_t                  q_data_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [swa_pkg::AVG_W-1:0] average_o,
  output logic [swa_pkg::CNT_W-1:0]       samples_in_window_o
);
  import swa_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [DIVD_W-1:0] POS_LIM = DIVD_W'((64'd1 << (AVG_W - 1)) - 64'd1);
  localparam logic [DIVD_W-1:0] NEG_LIM = DIVD_W'(64'd1 << (AVG_W - 1));

  logic [1:0]          state_q;
  logic [STEP_W-1:0]   step_q;
  logic                neg_q;
  logic [CNT_W-1:0]    div_q;
  logic [CNT_W:0]      rem_q;
  logic [DIVD_W-1:0]   dq_q;

  logic [CNT_W:0]      rem_sh;
  logic                qbit;
  logic [SUM_W-1:0]    mag;
  logic [DIVD_W-1:0]   lim;
  logic [AVG_W-1:0]    mag_res;
  logic [AVG_W-1:0]    res;
  logic                out_free;

  logic                out_valid_q;
  logic [AVG_W-1:0]    avg_q;
  logic [CNT_W-1:0]    siw_q;

  assign mag    = q_data_i.sum[SUM_W-1] ? SUM_W'(-q_data_i.sum) : SUM_W'(q_data_i.sum);
  assign rem_sh = {rem_q[CNT_W-1:0], dq_q[DIVD_W-1]};
  assign qbit   = rem_sh >= {1'b0, div_q};

  // quotient can not exceed 2^(AVG_W-1); clamp kept as a guard
  assign lim     = neg_q ? NEG_LIM : POS_LIM;
  assign mag_res = (dq_q > lim) ? lim[AVG_W-1:0] : dq_q[AVG_W-1:0];
  assign res     = neg_q ? AVG_W'(-mag_res) : mag_res;

  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = (state_q == ST_IDLE) && q_valid_i;

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          neg_q <= q_data_i.sum[SUM_W-1];
          div_q <= q_data_i.count;
          rem_q <= '0;
          dq_q  <= {mag, {FRAC_W{1'b0}}};
        end
      end
      ST_DIV: begin
        rem_q <= qbit ? rem_sh - {1'b0, div_q} : rem_sh;
        dq_q  <= {dq_q[DIVD_W-2:0], qbit};
      end
      default: begin
      end
    endcase
    if (state_q == ST_DONE && out_free) begin
      avg_q <= res;
      siw_q <= div_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          step_q <= '0;
          if (q_valid_i) begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(DIVD_W - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o         = out_valid_q;
  assign average_o           = avg_q;
  assign samples_in_window_o = siw_q;

endmodule

[src/sliding_window_moving_average_unit.sv]
// Boxcar moving average over the last win_len samples (1..256, 0 reads as 1,
// larger values as 256). The front end takes one sample per cycle while the queue
// has room; each result then goes through a bit-serial divider that resolves one
// quotient bit per cycle. A sample passes the sum register, the queue, the divider
// load, one divide step per quotient bit and the output register; the divider takes
// no new item until its last result is in the output register. Writing win_len
// clears the history; do so only when idle. The history ring needs no clearing pass
// after reset. Depends on swa_pkg, swa_front, swa_queue and swa_back.
`timescale 1ns / 1ps

module sliding_window_moving_average_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 win_len_we_i,
  input  logic [swa_pkg::CNT_W-1:0]            win_len_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [swa_pkg::SAMPLE_W-1:0]  sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [swa_pkg::AVG_W-1:0]     average_o,
  output logic [swa_pkg::CNT_W-1:0]            samples_in_window_o
);
  import swa_pkg::*;

  logic    push;
  work_t   push_data;
  q_stat_t q_stat;
  logic    q_valid;
  work_t   q_data;
  logic    pop;

  swa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .win_len_we_i (win_len_we_i),
    .win_len_i    (win_len_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .q_stat_i     (q_stat),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  swa_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (q_data),
    .stat_o      (q_stat)
  );

  swa_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .q_valid_i           (q_valid),
    .q_data_i            (q_data),
    .pop_o               (pop),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .average_o           (average_o),
    .samples_in_window_o (samples_in_window_o)
  );

endmodule

[src/swa_checker.sv]
// Port-level checks for the moving average unit, bound to the top level.
// Depends on swa_pkg.
`timescale 1ns / 1ps

module swa_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                win_len_we_i,
  input logic [swa_pkg::CNT_W-1:0]           win_len_i,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [swa_pkg::AVG_W-1:0]    average_o,
  input logic [swa_pkg::CNT_W-1:0]           samples_in_window_o
);
  import swa_pkg::*;

  logic [3:0]       pend_q;
  logic [CNT_W-1:0] win_q;
  logic             in_acc, out_acc;

  assign in_acc  = in_valid_i & in_ready_o;
  assign out_acc = out_valid_o & out_ready_i;

  // items accepted but not yet delivered, and the clamped window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      win_q  <= CNT_W'(1);
    end else begin
      pend_q <= pend_q + 4'(in_acc) - 4'(out_acc);
      if (win_len_we_i) begin
        if (win_len_i == '0) begin
          win_q <= CNT_W'(1);
        end else if (win_len_i > CNT_W'(MAX_WINDOW)) begin
          win_q <= CNT_W'(MAX_WINDOW);
        end else begin
          win_q <= win_len_i;
        end
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(average_o) && $stable(samples_in_window_o))
    else $error("result changed while stalled");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pend_q != '0)
    else $error("result without an outstanding item");

  a_count_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> samples_in_window_o != '0)
    else $error("empty sample count");

  a_count_win: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> samples_in_window_o <= win_q)
    else $error("sample count beyond window");

endmodule

bind sliding_window_moving_average_unit swa_checker u_swa_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .win_len_we_i        (win_len_we_i),
  .win_len_i           (win_len_i),
  .in_valid_i          (in_valid_i),
  .in_ready_o          (in_ready_o),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .average_o           (average_o),
  .samples_in_window_o (samples_in_window_o)
);

[test/tb_sliding_window_moving_average_unit.sv]
// Self-checking testbench for sliding_window_moving_average_unit: a directed table, then
// random phases over many settings, each average checked against the table or a boxcar model.
// Depends on swa_pkg and the RTL of the block; needs no files or arguments.
`timescale 1ns / 1ps

module tb_sliding_window_moving_average_unit;
  import swa_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 80;
  localparam int IDLE_PCT       = 24;
  localparam int NUM_ROWS       = 29;

  typedef enum logic { ROW_CONFIG, ROW_SAMPLE } row_kind_e;

  typedef struct packed {
    logic signed [AVG_W-1:0] avg;
    logic [CNT_W-1:0]        cnt;
  } mean_t;

  typedef struct packed {
    row_kind_e               kind;
    logic [CNT_W-1:0]        win;
    logic [SAMPLE_W-1:0]     smp;
    logic                    chk;
    logic signed [AVG_W-1:0] avg;
    logic [CNT_W-1:0]        cnt;
  } stim_row_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       win_len_we_i;
  logic [CNT_W-1:0]           win_len_i;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic signed [SAMPLE_W-1:0] sample_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic signed [AVG_W-1:0]    average_o;
  logic [CNT_W-1:0]           samples_in_window_o;

  // local copy of the averaging state
  logic [CNT_W-1:0]           win_setting;
  logic signed [SAMPLE_W-1:0] hist_ring [MAX_WINDOW];
  logic [PTR_W-1:0]           hist_wp;
  logic [CNT_W-1:0]           hist_fill;
  logic signed [SUM_W-1:0]    hist_sum;

  mean_t pending_means [$];
  logic  typed_on;
  mean_t typed_mean;
  logic  quiet;
  int    mismatches;
  int    samples_sent;
  int    means_checked;
  int    settings_written;
  int    stall_cycles;

  stim_row_t directed_rows [NUM_ROWS] = '{
    // window 1 after reset: average is the sample itself
    '{ROW_SAMPLE, 9'd0,   32'h0000_0000, 1'b1, 48'h0000_0000_0000, 9'd1},
    '{ROW_SAMPLE, 9'd0,   32'h7FFF_FFFF, 1'b1, 48'h7FFF_FFFF_0000, 9'd1},
    '{ROW_SAMPLE, 9'd0,   32'h8000_0000, 1'b1, 48'h8000_0000_0000, 9'd1},
    '{ROW_SAMPLE, 9'd0,   32'hFFFF_FFFF, 1'b1, 48'hFFFF_FFFF_0000, 9'd1},
    '{ROW_SAMPLE, 9'd0,   32'h0000_0001, 1'b1, 48'h0000_0001_0000, 9'd1},
    // zero window acts as one
    '{ROW_CONFIG, 9'd0,   32'h0000_0000, 1'b0, 48'h0000_0000_0000, 9'd0},
    '{ROW_SAMPLE, 9'd0,   32'h0000_0005, 1'b1, 48'h0000_0005_0000, 9'd1},
    '{ROW_SAMPLE, 9'd0,   32'hFFFF_FFF9, 1'b1, 48'hFFFF_FFF9_0000, 9'd1},
    '{ROW_CONFIG, 9'd2,   32'h0000_0000, 1'b0, 48'h0000_0000_0000, 9'd0},
    '{ROW_SAMPLE, 9'd0,   32'h7FFF_FFFF, 1'b1, 48'h7FFF_FFFF_0000, 9'd1},
    '{ROW_SAMPLE, 9'd0,   32'h7FFF_FFFF, 1'b1, 48'h7FFF_FFFF_0000, 9'd2},
    '{ROW_SAMPLE, 9'd0,   32'h7FFF_FFFF, 1'b1, 48'h7FFF_FFFF_0000, 9'd2},
    '{ROW_SAMPLE, 9'd0,   32'h8000_0000, 1'b0, 48'h0000_0000_0000, 9'd0},
    '{ROW_SAMPLE, 9'd0,   32'h8000_0000, 1'b1, 48'h8000_0000_0000, 9'd2},
    '{ROW_CONFIG, 9'd3,   32'h0000_0000, 1'b0, 48'h0000_0000_0000, 9'd0},
    '{ROW_SAMPLE, 9'd0,   32'h0000_0001, 1'b1, 48'h0000_0001_0000, 9'd1},
    '{ROW_SAMPLE, 9'd0,   32'h0000_0002, 1'b1, 48'h0000_0001_8000, 9'd2},
    '{ROW_SAMPLE, 9'd0,   32'h0000_0000, 1'b1, 48'h0000_0001_0000, 9'd3},
    '{ROW_SAMPLE, 9'd0,   32'hFFFF_FFFC, 1'b0, 48'h0000_0000_0000, 9'd0},
    '{ROW_SAMPLE, 9'd0,   32'h0000_0003, 1'b0, 48'h0000_0000_0000, 9'd0},
    // oversized window saturates to the ring depth
    '{ROW_CONFIG, 9'd511, 32'h0000_0000, 1'b0, 48'h0000_0000_0000, 9'd0},
    '{ROW_SAMPLE, 9'd0,   32'h7FFF_FFFF, 1'b1, 48'h7FFF_FFFF_0000, 9'd1},
    '{ROW_SAMPLE, 9'd0,   32'h8000_0000, 1'b0, 48'h0000_0000_0000, 9'd0},
    '{ROW_SAMPLE, 9'd0,   32'h1234_5678, 1'b0, 48'h0000_0000_0000, 9'd0},
    '{ROW_CONFIG, 9'd256, 32'h0000_0000, 1'b0, 48'h0000_0000_0000, 9'd0},
    '{ROW_SAMPLE, 9'd0,   32'h8000_0000, 1'b1, 48'h8000_0000_0000, 9'd1},
    '{ROW_SAMPLE, 9'd0,   32'h8000_0000, 1'b1, 48'h8000_0000_0000, 9'd2},
    '{ROW_SAMPLE, 9'd0,   32'h5555_5555, 1'b0, 48'h0000_0000_0000, 9'd0},
    '{ROW_SAMPLE, 9'd0,   32'hAAAA_AAAA, 1'b0, 48'h0000_0000_0000, 9'd0}
  };

  sliding_window_moving_average_unit dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .win_len_we_i        (win_len_we_i),
    .win_len_i           (win_len_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .sample_i            (sample_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .average_o           (average_o),
    .samples_in_window_o (samples_in_window_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic void clear_window(input logic [CNT_W-1:0] win);
    win_setting = win;
    hist_wp     = '0;
    hist_fill   = '0;
    hist_sum    = '0;
    foreach (hist_ring[i]) hist_ring[i] = '0;
  endfunction

  // push one sample into the boxcar and return the truncated fixed-point mean
  function automatic mean_t advance_window(input logic signed [SAMPLE_W-1:0] s);
    int unsigned      w;
    logic [PTR_W-1:0] oldest;
    longint           mag;
    longint           quo;
    logic             neg;
    mean_t            m;
    w = (win_setting == 0) ? 1 : (win_setting > MAX_WINDOW) ? MAX_WINDOW : win_setting;
    hist_sum = hist_sum + s;
    if (hist_fill >= w) begin
      oldest    = hist_wp - PTR_W'(hist_fill);
      hist_sum  = hist_sum - hist_ring[oldest];
      hist_fill = hist_fill - 1'b1;
    end
    hist_ring[hist_wp] = s;
    hist_wp   = hist_wp + 1'b1;
    hist_fill = hist_fill + 1'b1;
    neg = hist_sum < 0;
    mag = neg ? -longint'(hist_sum) : longint'(hist_sum);
    quo = (mag <<< FRAC_W) / longint'(hist_fill);
    if (neg) quo = -quo;
    m.avg = quo[AVG_W-1:0];
    m.cnt = hist_fill;
    return m;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return SAMPLE_W'(int'($urandom_range(0, 32)) - 16);
      default: return $urandom();
    endcase
  endfunction

  // track the block at every edge: register writes, accepted samples, returned averages
  always @(posedge clk_i) begin
    mean_t got_mean;
    mean_t want;
    if (rst_ni) begin
      if (win_len_we_i) clear_window(win_len_i);
      if (in_valid_i && in_ready_o) begin
        got_mean = advance_window(sample_i);
        pending_means.push_back(typed_on ? typed_mean : got_mean);
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_means.size() == 0) begin
          $error("average %0d over %0d with no sample pending", average_o,
                 samples_in_window_o);
          mismatches++;
        end else begin
          want = pending_means.pop_front();
          means_checked++;
          if (average_o !== want.avg) begin
            $error("average: expected %0d, got %0d", want.avg, average_o);
            mismatches++;
          end
          if (samples_in_window_o !== want.cnt) begin
            $error("samples_in_window: expected %0d, got %0d", want.cnt, samples_in_window_o);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("sliding_window_moving_average_unit verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // entered and left on a falling edge; valid stays up across back-to-back items
  task automatic push_sample(input logic [SAMPLE_W-1:0] s);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    samples_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_means.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_window(input logic [CNT_W-1:0] win);
    drain_results();
    win_len_we_i <= 1'b1;
    win_len_i    <= win;
    @(negedge clk_i);
    win_len_we_i <= 1'b0;
    settings_written++;
  endtask

  // min_lead samples of the most negative value first, to drive the sum to its limit
  task automatic run_phase(input logic [CNT_W-1:0] win, input int n, input int min_lead,
                           input logic calm, input int hold_at);
    write_window(win);
    quiet = calm;
    for (int k = 0; k < n; k++) begin
      if (k == hold_at) drain_results();
      push_sample(k < min_lead ? 32'h8000_0000 : pick_sample());
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_ni           = 1'b0;
    win_len_we_i     = 1'b0;
    win_len_i        = '0;
    in_valid_i       = 1'b0;
    sample_i         = '0;
    out_ready_i      = 1'b0;
    quiet            = 1'b0;
    typed_on         = 1'b0;
    typed_mean       = '0;
    mismatches       = 0;
    samples_sent     = 0;
    means_checked    = 0;
    settings_written = 0;
    stall_cycles     = 0;
    clear_window(9'd1);
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CONFIG) begin
        write_window(directed_rows[i].win);
      end else begin
        typed_on       = directed_rows[i].chk;
        typed_mean.avg = directed_rows[i].avg;
        typed_mean.cnt = directed_rows[i].cnt;
        push_sample(directed_rows[i].smp);
        typed_on = 1'b0;
      end
    end

    run_phase(9'd256, 280, 260, 1'b0, -1);
    run_phase(9'd511, 260, 0, 1'b1, 130);
    run_phase(9'd0, 25, 0, 1'b0, $urandom_range(1, 24));
    run_phase(9'd1, 25, 0, 1'b0, -1);
    run_phase(9'd2, 25, 0, 1'b0, $urandom_range(1, 24));
    run_phase(CNT_W'($urandom_range(3, 16)), 25, 0, 1'b0, -1);
    run_phase(CNT_W'($urandom_range(17, 254)), 25, 0, 1'b0, $urandom_range(1, 24));
    run_phase(CNT_W'($urandom_range(257, 510)), 25, 0, 1'b0, -1);
    run_phase(9'd255, 25, 0, 1'b0, $urandom_range(1, 24));
    run_phase(CNT_W'($urandom_range(0, 511)), 25, 0, 1'b0, -1);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("%0d samples sent across %0d window writes (0 through 511, full ring wrap)",
             samples_sent, settings_written);
    $display("%0d averages compared, %0d mismatches", means_checked, mismatches);
    if (mismatches == 0) begin
      $display("sliding_window_moving_average_unit verification clean");
    end else begin
      $display("sliding_window_moving_average_unit verification failed");
    end
    $finish;
  end

endmodule

[files.f]
src/swa_pkg.sv
src/swa_front.sv
src/swa_queue.sv
src/swa_back.sv
src/sliding_window_moving_average_unit.sv
src/swa_checker.sv
test/tb_sliding_window_moving_average_unit.sv
